// ===== rtl/lexd_pkg.sv =====
// shared types and constants for the 3x3 local extrema detector
`default_nettype none

package lexd_pkg;

  // fixed widths of the configuration port and the result coordinates
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 6;
  localparam int COORD_BITS     = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  // grid size after reset
  localparam logic [CFG_DATA_BITS-1:0] GRID_DIM_RESET = 6'd10;

  // which cell a classification job covers
  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,  // cell one row up, one column left of the new sample
    KIND_EDGE  = 2'd1,  // rightmost cell one row up
    KIND_FLUSH = 2'd2   // cell of the final row, swept left to right
  } cell_kind_t;

  // column read relative to the cell under test
  typedef enum logic [1:0] {
    DIR_CENTRE = 2'd0,
    DIR_LEFT   = 2'd1,
    DIR_RIGHT  = 2'd2
  } rd_dir_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       accept;       // input transfer: write sample, step counters
    logic       load_cell;    // set up the next cell to classify
    cell_kind_t cell_kind;
    logic       flush_first;  // first cell of the final-row sweep
    logic       rd_en;        // read one column of the three row banks
    rd_dir_t    rd_dir;
    logic       emit;         // load the result register
    logic       emit_last;    // result is the last one for this input
  } lexd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_prev;   // accepted sample closes the cell up-left of it
    logic need_edge;   // accepted sample closes the rightmost cell of the row above
    logic need_flush;  // accepted sample is the last of the frame
    logic flush_done;  // current cell is the last one of the final-row sweep
    logic out_free;    // result register can take a value this cycle
  } lexd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lexd_ctrl.sv =====
// controller state machine: sequences cell jobs, column reads and result loads
`default_nettype none

module lexd_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire lexd_pkg::lexd_sts_t sts_i,
  output lexd_pkg::lexd_cmd_t      cmd_o
);
  import lexd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_NEXT = 7'b0000010,
    ST_RD_C = 7'b0000100,
    ST_RD_L = 7'b0001000,
    ST_RD_R = 7'b0010000,
    ST_WAIT = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_prev_r, pend_prev_nxt;
  logic   pend_edge_r, pend_edge_nxt;
  logic   pend_flush_r, pend_flush_nxt;
  logic   flush_started_r, flush_started_nxt;
  logic   last_cell;

  // no more jobs after the cell being emitted
  assign last_cell = !pend_prev_r && !pend_edge_r && (!pend_flush_r || sts_i.flush_done);

  assign in_ready_o = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt         = state_r;
    pend_prev_nxt     = pend_prev_r;
    pend_edge_nxt     = pend_edge_r;
    pend_flush_nxt    = pend_flush_r;
    flush_started_nxt = flush_started_r;
    cmd_o             = '0;
    cmd_o.cell_kind   = KIND_LEFT;
    cmd_o.rd_dir      = DIR_CENTRE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept      = 1'b1;
          pend_prev_nxt     = sts_i.need_prev;
          pend_edge_nxt     = sts_i.need_edge;
          pend_flush_nxt    = sts_i.need_flush;
          flush_started_nxt = 1'b0;
          state_nxt         = ST_NEXT;
        end
      end
      ST_NEXT: begin
        priority if (pend_prev_r) begin
          cmd_o.load_cell = 1'b1;
          cmd_o.cell_kind = KIND_LEFT;
          pend_prev_nxt   = 1'b0;
          state_nxt       = ST_RD_C;
        end else if (pend_edge_r) begin
          cmd_o.load_cell = 1'b1;
          cmd_o.cell_kind = KIND_EDGE;
          pend_edge_nxt   = 1'b0;
          state_nxt       = ST_RD_C;
        end else if (pend_flush_r) begin
          cmd_o.load_cell   = 1'b1;
          cmd_o.cell_kind   = KIND_FLUSH;
          cmd_o.flush_first = !flush_started_r;
          flush_started_nxt = 1'b1;
          state_nxt         = ST_RD_C;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_C: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_dir = DIR_CENTRE;
        state_nxt    = ST_RD_L;
      end
      ST_RD_L: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_dir = DIR_LEFT;
        state_nxt    = ST_RD_R;
      end
      ST_RD_R: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_dir = DIR_RIGHT;
        state_nxt    = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = last_cell;
          if (sts_i.flush_done) begin
            pend_flush_nxt    = 1'b0;
            flush_started_nxt = 1'b0;
          end
          state_nxt = last_cell ? ST_IDLE : ST_NEXT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and pending job flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pend_prev_r     <= 1'b0;
      pend_edge_r     <= 1'b0;
      pend_flush_r    <= 1'b0;
      flush_started_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      pend_prev_r     <= pend_prev_nxt;
      pend_edge_r     <= pend_edge_nxt;
      pend_flush_r    <= pend_flush_nxt;
      flush_started_r <= flush_started_nxt;
    end
  end

  // results only go into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded while result register busy");

  // an accepted sample blocks the input until its jobs are done
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.accept |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // after the last result of a run the input opens again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit && cmd_o.emit_last) |=> in_ready_o)
    else $error("input not ready after last result");

endmodule

`default_nettype wire

// ===== rtl/lexd_datapath.sv =====
// datapath: config registers, counters, three row banks, neighbor compare, result register
`default_nettype none

module lexd_datapath #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire signed [SAMPLE_BITS-1:0]            sample_i,
  input  wire                                     cfg_we_i,
  input  wire        [lexd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire        [lexd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire lexd_pkg::lexd_cmd_t                cmd_i,
  output lexd_pkg::lexd_sts_t                     sts_o,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic       [lexd_pkg::COORD_BITS-1:0]   out_cell_col_o,
  output logic       [lexd_pkg::COORD_BITS-1:0]   out_cell_row_o,
  output logic                                    out_is_peak_o,
  output logic                                    out_is_trough_o,
  output logic                                    out_last_of_run_o,
  output logic                                    out_frame_done_o
);
  import lexd_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [1:0] next3(input logic [1:0] x);
    next3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  logic [CFG_DATA_BITS-1:0] grid_w_r, grid_h_r;
  logic                     cfg_hit;
  logic [CW-1:0]            w_m1;
  logic [RW-1:0]            h_m1;
  logic [CW-1:0]            col_r, col_nxt, acc_col_r;
  logic [RW-1:0]            row_r, row_nxt, acc_row_r;
  logic [1:0]               lower_sel_r, wr_bank, up_idx, mid_idx;
  logic [CW-1:0]            cell_col_r;
  logic [RW-1:0]            cell_row_r;
  logic                     has_above_r, has_below_r, cell_flush_r;
  logic [CW-1:0]            rd_addr;
  logic                     rd_inb;
  logic signed [SAMPLE_BITS-1:0] rdata_r [3];
  logic                     tag_valid_r, tag_inb_r;
  rd_dir_t                  tag_dir_r;
  logic signed [SAMPLE_BITS-1:0] above_d, mid_d, below_d;
  logic signed [SAMPLE_BITS-1:0] centre_r, centre_nxt;
  logic                     peak_r, peak_nxt, valley_r, valley_nxt;
  logic                     flush_done;
  logic                     out_valid_r;
  logic [COORD_BITS-1:0]    out_col_r, out_row_r;
  logic                     out_peak_r, out_valley_r, out_last_r, out_done_r;

  // configuration registers; a write restarts the frame
  assign cfg_hit = cfg_we_i &&
                   (cfg_index_i == CFG_GRID_WIDTH || cfg_index_i == CFG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_DIM_RESET;
      grid_h_r <= GRID_DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_GRID_WIDTH) begin
        grid_w_r <= cfg_wdata_i;
      end else if (cfg_index_i == CFG_GRID_HEIGHT) begin
        grid_h_r <= cfg_wdata_i;
      end
    end
  end

  // clamped last column and last row
  always_comb begin
    if (grid_w_r == '0) begin
      w_m1 = '0;
    end else if (int'(grid_w_r) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(grid_w_r - 6'd1);
    end
    if (grid_h_r == '0) begin
      h_m1 = '0;
    end else if (int'(grid_h_r) > MAX_HEIGHT) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(grid_h_r - 6'd1);
    end
  end

  // raster position of the next sample and bank rotation
  assign col_nxt = (col_r == w_m1) ? '0 : col_r + 1'b1;
  assign row_nxt = (col_r != w_m1) ? row_r : ((row_r == h_m1) ? '0 : row_r + 1'b1);
  assign wr_bank = (col_r == '0) ? next3(lower_sel_r) : lower_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      lower_sel_r <= 2'd0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd_i.accept) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      lower_sel_r <= wr_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      acc_col_r <= col_r;
      acc_row_r <= row_r;
    end
  end

  // jobs that the sample at the current position will cause
  assign sts_o.need_prev  = (row_r != '0) && (col_r != '0);
  assign sts_o.need_edge  = (row_r != '0) && (col_r == w_m1);
  assign sts_o.need_flush = (row_r == h_m1) && (col_r == w_m1);
  assign flush_done       = cell_flush_r && (cell_col_r == w_m1);
  assign sts_o.flush_done = flush_done;
  assign sts_o.out_free   = !out_valid_r || out_ready_i;

  // cell under test
  always_ff @(posedge clk) begin
    if (cmd_i.load_cell) begin
      unique case (cmd_i.cell_kind)
        KIND_LEFT: begin
          cell_col_r   <= acc_col_r - 1'b1;
          cell_row_r   <= acc_row_r - 1'b1;
          has_above_r  <= (acc_row_r > RW'(1));
          has_below_r  <= 1'b1;
          cell_flush_r <= 1'b0;
        end
        KIND_EDGE: begin
          cell_col_r   <= w_m1;
          cell_row_r   <= acc_row_r - 1'b1;
          has_above_r  <= (acc_row_r > RW'(1));
          has_below_r  <= 1'b1;
          cell_flush_r <= 1'b0;
        end
        KIND_FLUSH: begin
          cell_col_r   <= cmd_i.flush_first ? '0 : cell_col_r + 1'b1;
          cell_row_r   <= acc_row_r;
          has_above_r  <= (acc_row_r != '0);
          has_below_r  <= 1'b0;
          cell_flush_r <= 1'b1;
        end
        default: begin
          cell_flush_r <= 1'b0;
        end
      endcase
    end
  end

  // column address for this read; off-grid columns are read but not compared
  always_comb begin
    rd_addr = cell_col_r;
    rd_inb  = 1'b1;
    unique case (cmd_i.rd_dir)
      DIR_CENTRE: rd_inb = 1'b1;
      DIR_LEFT: begin
        if (cell_col_r != '0) begin
          rd_addr = cell_col_r - 1'b1;
        end else begin
          rd_inb = 1'b0;
        end
      end
      DIR_RIGHT: begin
        if (cell_col_r != w_m1) begin
          rd_addr = cell_col_r + 1'b1;
        end else begin
          rd_inb = 1'b0;
        end
      end
      default: rd_inb = 1'b0;
    endcase
  end

  // three row banks, one write port and one registered read port each
  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (cmd_i.accept && wr_bank == 2'(g)) begin
        mem[col_r] <= sample_i;
      end
      if (cmd_i.rd_en) begin
        rdata_r[g] <= mem[rd_addr];
      end
    end
  end

  // read tag is registered alongside the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= 1'b0;
    end else begin
      tag_valid_r <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    tag_dir_r <= cmd_i.rd_dir;
    tag_inb_r <= rd_inb;
  end

  // map banks to rows; the final-row sweep looks one row lower
  assign up_idx  = next3(lower_sel_r);
  assign mid_idx = next3(up_idx);
  assign above_d = cell_flush_r ? rdata_r[mid_idx] : rdata_r[up_idx];
  assign mid_d   = cell_flush_r ? rdata_r[lower_sel_r] : rdata_r[mid_idx];
  assign below_d = rdata_r[lower_sel_r];

  // peak and valley accumulate over the three columns
  always_comb begin
    centre_nxt = centre_r;
    peak_nxt   = peak_r;
    valley_nxt = valley_r;
    if (tag_valid_r) begin
      if (tag_dir_r == DIR_CENTRE) begin
        centre_nxt = mid_d;
        peak_nxt   = (!has_above_r || mid_d > above_d) && (!has_below_r || mid_d > below_d);
        valley_nxt = (!has_above_r || mid_d < above_d) && (!has_below_r || mid_d < below_d);
      end else if (tag_inb_r) begin
        peak_nxt   = peak_r && (centre_r > mid_d) &&
                     (!has_above_r || centre_r > above_d) &&
                     (!has_below_r || centre_r > below_d);
        valley_nxt = valley_r && (centre_r < mid_d) &&
                     (!has_above_r || centre_r < above_d) &&
                     (!has_below_r || centre_r < below_d);
      end
    end
  end

  always_ff @(posedge clk) begin
    centre_r <= centre_nxt;
    peak_r   <= peak_nxt;
    valley_r <= valley_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_col_r    <= COORD_BITS'(cell_col_r);
      out_row_r    <= COORD_BITS'(cell_row_r);
      out_peak_r   <= peak_r;
      out_valley_r <= valley_r;
      out_last_r   <= cmd_i.emit_last;
      out_done_r   <= flush_done;
    end
  end

  assign out_valid_o       = out_valid_r;
  assign out_cell_col_o    = out_col_r;
  assign out_cell_row_o    = out_row_r;
  assign out_is_peak_o     = out_peak_r;
  assign out_is_trough_o   = out_valley_r;
  assign out_last_of_run_o = out_last_r;
  assign out_frame_done_o  = out_done_r;

  // the frame's final cell always closes its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_o && out_frame_done_o) |-> out_last_of_run_o)
    else $error("frame done without last of run");

  // bank reads never overlap a sample write
  a_rd_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.rd_en |-> !cmd_i.accept)
    else $error("bank read during sample write");

endmodule

`default_nettype wire

// ===== rtl/local_extrema_3x3_detector.sv =====
// top level of the 3x3 local extrema detector
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   in_sample_value
//   out      output     out_valid/out_ready cell_col, cell_row, is_peak, is_trough,
//                                           last_of_run, frame_done
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// A sample is accepted, then each result cell goes through job setup, three
// column reads of the row banks through their single read ports, compare and load;
// no new sample is accepted until all results of the last one are loaded.
// The last sample of a frame adds a sweep over the whole final row.
// Reset clears counters, configuration and control only; row banks hold garbage until written.
// A busy result register stalls the sequencer in its load step.
`default_nettype none

module local_extrema_3x3_detector #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire signed [SAMPLE_BITS-1:0]            in_sample_value,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic       [lexd_pkg::COORD_BITS-1:0]   out_cell_col,
  output logic       [lexd_pkg::COORD_BITS-1:0]   out_cell_row,
  output logic                                    out_is_peak,
  output logic                                    out_is_trough,
  output logic                                    out_last_of_run,
  output logic                                    out_frame_done,
  input  wire                                     cfg_we,
  input  wire        [lexd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire        [lexd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import lexd_pkg::*;

  lexd_cmd_t cmd;
  lexd_sts_t sts;

  // job sequencer
  lexd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and classification
  lexd_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_i          (in_sample_value),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_cell_col_o    (out_cell_col),
    .out_cell_row_o    (out_cell_row),
    .out_is_peak_o     (out_is_peak),
    .out_is_trough_o   (out_is_trough),
    .out_last_of_run_o (out_last_of_run),
    .out_frame_done_o  (out_frame_done)
  );

endmodule

`default_nettype wire
